// ----- hdl/tpr_pkg.sv -----
// shared types and constants of the turtle pen raster plotter
package tpr_pkg;

  localparam int GRID_DEF = 64;
  localparam int ROW_W    = 64;
  localparam int INDEX_W  = 6;
  localparam int OPCODE_W = 3;
  localparam int DIST_W   = 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PEN_UP   = 3'd0,
    OP_PEN_DOWN = 3'd1,
    OP_TURN_CW  = 3'd2,
    OP_TURN_CCW = 3'd3,
    OP_MOVE     = 3'd4,
    OP_DUMP     = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    HEAD_POS_X = 2'd0,
    HEAD_NEG_Y = 2'd1,
    HEAD_NEG_X = 2'd2,
    HEAD_POS_Y = 2'd3
  } heading_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_DUMP
  } state_e;

endpackage

// ----- hdl/turtle_pen_raster_plotter_unit.sv -----
// top level of the turtle pen raster plotter
// pen and turn commands, and moves with the pen up, complete on acceptance without raising busy
// a move with the pen down is busy while it marks each row it touches, one row if horizontal
// a dump is busy while it strobes one row per cycle, from row 0 up to row GRID-1
// the row store is a registered-read ram with per-row valid flops cleared at once by reset
// reset (asynchronous, active low) lifts the pen, heads +x and sets the position to 0,0
module turtle_pen_raster_plotter_unit
  import tpr_pkg::*;
#(
  parameter int GRID = GRID_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [DIST_W-1:0]   distance_i,
  output logic                result_valid_o,
  output logic [ROW_W-1:0]    row_bits_o,
  output logic [INDEX_W-1:0]  row_index_o,
  output logic                last_row_o
);

  localparam int CW   = $clog2(GRID);
  localparam int CNTW = $clog2(GRID + 1);

  state_e          state_q, state_d;
  logic            pen_q, pen_d;
  heading_e        head_q, head_d;
  logic [CW-1:0]   x_q, x_d;
  logic [CW-1:0]   y_q, y_d;
  logic [CNTW-1:0] left_q, left_d;
  logic            pend_q, pend_d;
  logic [CW-1:0]   row_q, row_d;
  logic [CW-1:0]   rd_row_q, rd_row_d;
  logic            row_up_q, row_up_d;
  logic [GRID-1:0] mask_q, mask_d;
  logic [GRID-1:0] valid_q;

  logic            accept;
  op_e             op;
  logic [CW-1:0]   x_end;
  logic [CW-1:0]   y_end;
  logic [CNTW-1:0] row_cnt;
  logic            row_up;
  logic [GRID-1:0] mask;
  logic            issue;
  logic            seq_done;
  logic            ram_we;
  logic [GRID-1:0] ram_rdata;
  logic [GRID-1:0] row_data;

  assign accept   = start && !busy;
  assign op       = op_e'(opcode_i);
  assign issue    = (state_q != ST_IDLE) && (left_q != '0);
  assign seq_done = (left_q == '0) && !pend_q;
  assign row_data = valid_q[rd_row_q] ? ram_rdata : '0;

  tpr_geom #(
    .GRID(GRID)
  ) u_geom (
    .x_i       (x_q),
    .y_i       (y_q),
    .head_i    (head_q),
    .distance_i(distance_i),
    .x_end_o   (x_end),
    .y_end_o   (y_end),
    .row_cnt_o (row_cnt),
    .row_up_o  (row_up),
    .mask_o    (mask)
  );

  tpr_ram #(
    .WIDTH(GRID),
    .DEPTH(GRID)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(rd_row_q),
    .wdata_i(row_data | mask_q),
    .re_i   (issue),
    .raddr_i(row_q),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (op == OP_MOVE) && pen_q) begin
          state_d = ST_MARK;
        end else if (accept && (op == OP_DUMP)) begin
          state_d = ST_DUMP;
        end
      end
      ST_MARK, ST_DUMP: begin
        if (seq_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy           = (state_q != ST_IDLE);
    ram_we         = (state_q == ST_MARK) && pend_q;
    result_valid_o = (state_q == ST_DUMP) && pend_q;
    row_bits_o     = ROW_W'(row_data);
    row_index_o    = INDEX_W'(rd_row_q);
    last_row_o     = (rd_row_q == CW'(GRID - 1));
  end

  // datapath
  always_comb begin
    pen_d    = pen_q;
    head_d   = head_q;
    x_d      = x_q;
    y_d      = y_q;
    left_d   = left_q;
    pend_d   = issue;
    row_d    = row_q;
    rd_row_d = rd_row_q;
    row_up_d = row_up_q;
    mask_d   = mask_q;
    if (issue) begin
      rd_row_d = row_q;
      left_d   = left_q - CNTW'(1);
      row_d    = row_up_q ? row_q + CW'(1) : row_q - CW'(1);
    end
    if (accept) begin
      unique case (op)
        OP_PEN_UP:   pen_d  = 1'b0;
        OP_PEN_DOWN: pen_d  = 1'b1;
        OP_TURN_CW:  head_d = heading_e'(head_q - 2'd1);
        OP_TURN_CCW: head_d = heading_e'(head_q + 2'd1);
        OP_MOVE: begin
          x_d = x_end;
          y_d = y_end;
          if (pen_q) begin
            row_d    = y_q;
            left_d   = row_cnt;
            row_up_d = row_up;
            mask_d   = mask;
          end
        end
        OP_DUMP: begin
          row_d    = '0;
          left_d   = CNTW'(GRID);
          row_up_d = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pen_q   <= 1'b0;
      head_q  <= HEAD_POS_X;
      x_q     <= '0;
      y_q     <= '0;
      left_q  <= '0;
      pend_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      pen_q   <= pen_d;
      head_q  <= head_d;
      x_q     <= x_d;
      y_q     <= y_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      if (ram_we) begin
        valid_q[rd_row_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    rd_row_q <= rd_row_d;
    row_up_q <= row_up_d;
    mask_q   <= mask_d;
  end

`ifndef SYNTHESIS
  a_no_write_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_MARK))
    else $error("row written outside a marking move");

  a_strobe_in_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (state_q == ST_DUMP) && busy)
    else $error("row strobed outside a dump");

  a_last_row_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_row_o) |=> !result_valid_o ##1 !busy)
    else $error("dump continues after its last row");

  a_dump_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_DUMP)) |=> busy && (left_q == CNTW'(GRID)))
    else $error("dump transaction did not start a full sweep");
`endif

endmodule

// ----- hdl/tpr_ram.sv -----
// generic simple dual-port ram with registered read
module tpr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/tpr_geom.sv -----
// move geometry: saturated end position, rows touched and cell mask
module tpr_geom
  import tpr_pkg::*;
#(
  parameter int GRID = GRID_DEF
) (
  input  logic [$clog2(GRID)-1:0]   x_i,
  input  logic [$clog2(GRID)-1:0]   y_i,
  input  heading_e                  head_i,
  input  logic [DIST_W-1:0]         distance_i,
  output logic [$clog2(GRID)-1:0]   x_end_o,
  output logic [$clog2(GRID)-1:0]   y_end_o,
  output logic [$clog2(GRID+1)-1:0] row_cnt_o,
  output logic                      row_up_o,
  output logic [GRID-1:0]           mask_o
);

  localparam int CW   = $clog2(GRID);
  localparam int CNTW = $clog2(GRID + 1);
  localparam logic [CW-1:0]   LastCoord = CW'(GRID - 1);
  localparam logic [GRID-1:0] Ones      = {GRID{1'b1}};

  logic [CW-1:0] room;
  logic [CW-1:0] n;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic          horiz;

  always_comb begin
    unique case (head_i)
      HEAD_POS_X: room = LastCoord - x_i;
      HEAD_NEG_X: room = x_i;
      HEAD_NEG_Y: room = y_i;
      HEAD_POS_Y: room = LastCoord - y_i;
      default:    room = '0;
    endcase
    n     = (distance_i < DIST_W'(room)) ? CW'(distance_i) : room;
    horiz = (head_i == HEAD_POS_X) || (head_i == HEAD_NEG_X);

    x_end_o = x_i;
    y_end_o = y_i;
    unique case (head_i)
      HEAD_POS_X: x_end_o = x_i + n;
      HEAD_NEG_X: x_end_o = x_i - n;
      HEAD_NEG_Y: y_end_o = y_i - n;
      HEAD_POS_Y: y_end_o = y_i + n;
      default: ;
    endcase

    lo = (head_i == HEAD_POS_X) ? x_i : x_end_o;
    hi = (head_i == HEAD_POS_X) ? x_end_o : x_i;

    mask_o    = horiz ? ((Ones << lo) & (Ones >> (LastCoord - hi)))
                      : (GRID'(1) << x_i);
    row_cnt_o = horiz ? CNTW'(1) : CNTW'(n) + CNTW'(1);
    row_up_o  = (head_i == HEAD_POS_Y);
  end

endmodule

// ----- test/tb_turtle_pen_raster_plotter_unit.sv -----
// self-checking testbench of the turtle pen raster plotter: command driver, row monitor, predictor
`timescale 1ns / 1ps

module tb_turtle_pen_raster_plotter_unit;
  import tpr_pkg::*;

  localparam int GRID           = GRID_DEF;
  localparam int RANDOM_ITEMS   = 195;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = GRID + 8;
  localparam logic [ROW_W-1:0] ROW_MASK =
    (GRID >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << GRID) - 1'b1);

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [DIST_W-1:0]   steps;
    int                  gap;
    bit                  drain;
  } plot_cmd_t;

  typedef struct {
    logic [ROW_W-1:0]   row_bits;
    logic [INDEX_W-1:0] row_index;
    logic               last_row;
  } canvas_row_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic [OPCODE_W-1:0] opcode_i       = '0;
  logic [DIST_W-1:0]   distance_i     = '0;
  logic                result_valid_o;
  logic [ROW_W-1:0]    row_bits_o;
  logic [INDEX_W-1:0]  row_index_o;
  logic                last_row_o;

  plot_cmd_t   pending_cmds[$];
  canvas_row_t expected_rows[$];

  logic [ROW_W-1:0] canvas_model [GRID];
  logic             pen_is_down;
  logic [1:0]       turtle_heading;
  int               pos_x;
  int               pos_y;

  int gap_left;
  int idle_cycles;
  int mismatches;
  int rows_checked;
  int cmd_count [8];

  turtle_pen_raster_plotter_unit #(
    .GRID(GRID)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .distance_i    (distance_i),
    .result_valid_o(result_valid_o),
    .row_bits_o    (row_bits_o),
    .row_index_o   (row_index_o),
    .last_row_o    (last_row_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic plot_command(input logic [OPCODE_W-1:0] op, input logic [DIST_W-1:0] steps);
    canvas_row_t row;
    case (op)
      OP_PEN_UP:   pen_is_down = 1'b0;
      OP_PEN_DOWN: pen_is_down = 1'b1;
      OP_TURN_CW:  turtle_heading = turtle_heading - 2'd1;
      OP_TURN_CCW: turtle_heading = turtle_heading + 2'd1;
      OP_MOVE: begin
        if (pen_is_down) canvas_model[pos_y][pos_x] = 1'b1;
        for (int i = 0; i < int'(steps); i++) begin
          case (turtle_heading)
            HEAD_POS_X: if (pos_x < GRID - 1) pos_x++;
            HEAD_NEG_Y: if (pos_y > 0) pos_y--;
            HEAD_NEG_X: if (pos_x > 0) pos_x--;
            default:    if (pos_y < GRID - 1) pos_y++;
          endcase
          if (pen_is_down) canvas_model[pos_y][pos_x] = 1'b1;
        end
      end
      OP_DUMP: begin
        for (int r = 0; r < GRID; r++) begin
          row.row_bits  = canvas_model[r] & ROW_MASK;
          row.row_index = INDEX_W'(r);
          row.last_row  = (r == GRID - 1);
          expected_rows.push_back(row);
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_cmd(input logic [OPCODE_W-1:0] op, input logic [DIST_W-1:0] steps,
                         input int gap, input bit drain);
    plot_cmd_t c;
    c.op    = op;
    c.steps = steps;
    c.gap   = gap;
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  // driver: holds each transaction until accepted, then waits out the gap of the next
  always @(posedge clk_i) begin : driver
    logic fire;
    logic load;
    fire = 1'b0;
    load = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        plot_command(opcode_i, distance_i);
        cmd_count[opcode_i]++;
        void'(pending_cmds.pop_front());
        gap_left = (pending_cmds.size() != 0) ? pending_cmds[0].gap : 0;
      end else if (start) begin
        fire = 1'b1;
      end
      if (!fire && pending_cmds.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pending_cmds[0].drain && expected_rows.size() != 0)) begin
          fire = 1'b1;
          load = 1'b1;
        end
      end
      start <= fire;
      if (load) begin
        opcode_i   <= pending_cmds[0].op;
        distance_i <= pending_cmds[0].steps;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    canvas_row_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected row %0d", row_index_o));
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (row_bits_o !== want.row_bits)
          report_mismatch($sformatf("row %0d bits %h, expected %h",
                                    want.row_index, row_bits_o, want.row_bits));
        if (row_index_o !== want.row_index)
          report_mismatch($sformatf("row index %0d, expected %0d",
                                    row_index_o, want.row_index));
        if (last_row_o !== want.last_row)
          report_mismatch($sformatf("row %0d last flag %b, expected %b",
                                    want.row_index, last_row_o, want.last_row));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) ||
        (result_valid_o === 1'b1 && expected_rows.size() != 0)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int  useful;
    int  r;
    bit  quiet;
    logic [OPCODE_W-1:0] op;
    logic [DIST_W-1:0]   steps;

    for (int i = 0; i < GRID; i++) canvas_model[i] = '0;
    for (int i = 0; i < 8; i++) cmd_count[i] = 0;
    pen_is_down    = 1'b0;
    turtle_heading = HEAD_POS_X;
    pos_x          = 0;
    pos_y          = 0;
    gap_left       = 0;
    idle_cycles    = 0;
    mismatches     = 0;
    rows_checked   = 0;

    // directed: empty canvas, edges, zero distance, turn wrap, ignored opcodes
    add_cmd(OP_DUMP,     8'h00, 0, 1'b0);
    add_cmd(OP_MOVE,     8'd5,  0, 1'b1);
    add_cmd(OP_PEN_DOWN, 8'hff, 0, 1'b0);
    add_cmd(OP_MOVE,     8'd0,  1, 1'b0);
    add_cmd(OP_MOVE,     8'hff, 0, 1'b0);
    add_cmd(OP_TURN_CCW, 8'h00, 2, 1'b0);
    add_cmd(OP_MOVE,     8'd3,  0, 1'b0);
    add_cmd(OP_TURN_CW,  8'h5a, 0, 1'b0);
    add_cmd(OP_TURN_CW,  8'ha5, 0, 1'b0);
    add_cmd(OP_MOVE,     8'hff, 0, 1'b0);
    add_cmd(OP_TURN_CW,  8'h00, 0, 1'b0);
    add_cmd(OP_MOVE,     8'hff, 3, 1'b0);
    add_cmd(OP_TURN_CW,  8'h00, 0, 1'b0);
    add_cmd(OP_MOVE,     8'hff, 0, 1'b0);
    add_cmd(3'(OP_DUMP + 1), 8'haa, 0, 1'b0);
    add_cmd(3'(OP_DUMP + 2), 8'h55, 0, 1'b0);
    add_cmd(OP_PEN_UP,   8'hff, 0, 1'b0);
    add_cmd(OP_MOVE,     8'd10, 0, 1'b0);
    add_cmd(OP_DUMP,     8'hff, 0, 1'b0);
    for (int i = 0; i < 4; i++) add_cmd(OP_TURN_CCW, 8'h00, 0, 1'b0);
    add_cmd(OP_MOVE,     8'd7,  0, 1'b0);
    add_cmd(OP_DUMP,     8'h00, 0, 1'b0);

    // random: mostly pen-down walks with turns, some noise and dumps
    useful = 0;
    quiet  = 1'b0;
    while (useful < RANDOM_ITEMS) begin
      if (useful % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
      r     = $urandom_range(0, 99);
      steps = DIST_W'($urandom_range(0, 255));
      if (r < 6)       op = 3'($urandom_range(OP_DUMP + 1, (1 << OPCODE_W) - 1));
      else if (r < 14) op = OP_PEN_UP;
      else if (r < 30) op = OP_PEN_DOWN;
      else if (r < 45) op = OP_TURN_CW;
      else if (r < 58) op = OP_TURN_CCW;
      else if (r < 90) op = OP_MOVE;
      else             op = OP_DUMP;
      if (op == OP_MOVE) begin
        r = $urandom_range(0, 99);
        if (r < 70)      steps = DIST_W'($urandom_range(0, 12));
        else if (r < 90) steps = DIST_W'($urandom_range(13, 63));
      end
      add_cmd(op, steps, pick_gap(quiet), $urandom_range(0, 99) < 3);
      if (op <= OP_DUMP) useful++;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((pending_cmds.size() != 0 || expected_rows.size() != 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk_i);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      report_mismatch($sformatf("watchdog expired, %0d commands and %0d rows outstanding",
                                pending_cmds.size(), expected_rows.size()));
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      if (expected_rows.size() != 0)
        report_mismatch($sformatf("%0d rows never arrived", expected_rows.size()));
    end

    $display("ran %0d pen, %0d turn, %0d move, %0d dump and %0d unused-opcode commands",
             cmd_count[OP_PEN_UP] + cmd_count[OP_PEN_DOWN],
             cmd_count[OP_TURN_CW] + cmd_count[OP_TURN_CCW],
             cmd_count[OP_MOVE], cmd_count[OP_DUMP], cmd_count[6] + cmd_count[7]);
    $display("compared %0d canvas rows, %0d mismatches", rows_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
